@@ sv/kkde_pkg.sv @@
// Shared constants, codes and the exponential series for the kNN kernel density estimator.
package kkde_pkg;

    // Parameter defaults
    localparam int MAX_NEIGHBORS_DEF  = 64;
    localparam int EXP_TABLE_SIZE_DEF = 256;

    // Field widths
    localparam int DIST_W   = 16;
    localparam int EST_W    = 64;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 2;

    // Divider datapath: 128-bit denominator shifted by 64, numerator shifted by up to 72
    localparam int DEN_LIMBS = 4;
    localparam int DIV_W     = 192;
    localparam int QUO_W     = 65;
    localparam int STEP_W    = 7;
    localparam int EXP_W     = 33;

    // Kernel codes
    localparam logic [CFG_W-1:0] KIND_EPAN  = 2'd0;
    localparam logic [CFG_W-1:0] KIND_CONE  = 2'd1;
    localparam logic [CFG_W-1:0] KIND_GAUSS = 2'd2;
    localparam logic [CFG_W-1:0] KIND_SILV  = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SAT      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_RAD = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

    // Register indexes
    localparam logic REG_KIND = 1'b0;
    localparam logic REG_DIMS = 1'b1;

    // beta/2 in Q0.32, beta = 1.953
    localparam longint unsigned HALF_BETA_Q32 = 64'd4194035565;

    // Unsigned 64-bit quotient by shift and subtract; used at elaboration only
    function automatic longint unsigned f_udiv(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned rem;
        longint unsigned quo;
        rem = 64'd0;
        quo = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-x) for Q0.32 x by the alternating series; used at elaboration only
    function automatic longint unsigned f_expq(input longint unsigned x);
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        term = 64'd1 << 32;
        pos  = term;
        neg  = 64'd0;
        for (longint unsigned n = 1; n < 64 && term != 0; n++) begin
            term = f_udiv((term * x) >> 32, n);
            if (n[0]) neg += term;
            else      pos += term;
        end
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    localparam longint unsigned E_ONE_L  = f_expq(HALF_BETA_Q32);
    localparam longint unsigned E_BETA_L = (E_ONE_L * E_ONE_L) >> 32;

    localparam logic [EXP_W-1:0] E_ONE  = EXP_W'(E_ONE_L);
    localparam logic [EXP_W-1:0] E_BETA = EXP_W'(E_BETA_L);
    // (1 - e^-beta) in Q0.32
    localparam logic [31:0] G_SCALE = 32'((64'd1 << 32) - E_BETA_L);

endpackage

@@ sv/kkde_store.sv @@
// Distance store: one write port, one registered read port.
module kkde_store import kkde_pkg::*; #(
    parameter int DEPTH = MAX_NEIGHBORS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DIST_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DIST_W-1:0] o_q
);

    logic [DIST_W-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_q <= r_mem[i_raddr];
        end
    end

endmodule

@@ sv/kkde_mul.sv @@
// Shared 32x32 multiplier with a 32-bit carry-in add.
module kkde_mul import kkde_pkg::*; (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    output logic [63:0] o_p
);

    assign o_p = (64'(i_a) * 64'(i_b)) + 64'(i_c);

endmodule

@@ sv/kkde_div.sv @@
// Restoring divider, one quotient bit per cycle.
module kkde_div import kkde_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_num,
    input  logic [DIV_W-1:0]  i_dsh,
    input  logic [STEP_W-1:0] i_steps,
    output logic              o_done,
    output logic [QUO_W-1:0]  o_quo
);

    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dsh;
    logic [STEP_W-1:0] r_left;
    logic              r_busy;
    logic              w_ge;

    assign w_ge = (r_rem >= r_dsh);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_left <= '0;
        end else begin
            o_done <= !i_start && r_busy && (r_left == STEP_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_left <= i_steps;
            end else if (r_busy) begin
                r_left <= r_left - STEP_W'(1);
                if (r_left == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: compare, subtract, shift divisor down
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= i_dsh;
            o_quo <= '0;
        end else if (r_busy) begin
            if (w_ge) r_rem <= r_rem - r_dsh;
            r_dsh <= r_dsh >> 1;
            o_quo <= {o_quo[QUO_W-2:0], w_ge};
        end
    end

endmodule

@@ sv/knn_kernel_density_estimator_unit.sv @@
// Top level: loader, sequencer and result register of the kNN kernel density estimator.
//
// Input channel (i_valid / o_stall, i_distance, i_last): one neighbor distance per
// transaction, ascending. A transaction with i_last ends the set; its distance is the
// radius R. After the ending transaction o_stall stays high while one shared 32x32
// multiplier and one restoring divider do the work (skipped if the set overflowed or R
// is zero): R squared; per distance a read, a square and an accumulate (plus a Silverman
// square, or a table index by division for a Gaussian distance below R); per
// denominator factor (each power of R, plus the Gaussian scale) one product per limb;
// the 65-step quotient; the load of the output register. The input is ready again in
// the same cycle in which o_valid rises.
// Output channel (o_valid / i_stall, o_estimate, o_count, o_status): one transaction
// per set. The result sits in an output register; while the receiver stalls, new
// distances are still loaded, but the next set's result waits until it is taken.
// Configuration (i_wr_en, i_wr_index, i_wr_data): kernel kind and dims; the user must write them idle, not enforced.
// Reset (synchronous, active low) empties the set and the output register and sets
// kernel 0, dims 2. The distance store is not cleared; only loaded entries are read.
module knn_kernel_density_estimator_unit import kkde_pkg::*; #(
    parameter int MAX_NEIGHBORS  = MAX_NEIGHBORS_DEF,
    parameter int EXP_TABLE_SIZE = EXP_TABLE_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [DIST_W-1:0]   i_distance,
    input  logic                i_last,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [EST_W-1:0]    o_estimate,
    output logic [COUNT_W-1:0]  o_count,
    output logic [STATUS_W-1:0] o_status,
    input  logic                i_wr_en,
    input  logic                i_wr_index,
    input  logic [CFG_W-1:0]    i_wr_data
);

    localparam int AW   = $clog2(MAX_NEIGHBORS);
    localparam int CW   = $clog2(MAX_NEIGHBORS + 1);
    localparam int NUMW = EST_W + $clog2(MAX_NEIGHBORS) + 1;
    localparam int QB   = $clog2(EXP_TABLE_SIZE);
    localparam int EW   = 32 + QB + 1;

    typedef logic [EXP_W-1:0] t_exp_tab [EXP_TABLE_SIZE];

    // exp(-beta/2 * i / size) table, built at elaboration
    function automatic t_exp_tab f_build_tab();
        t_exp_tab tab;
        for (int i = 0; i < EXP_TABLE_SIZE; i++) begin
            tab[i] = EXP_W'(f_expq(f_udiv(HALF_BETA_Q32 * 64'(i), 64'(EXP_TABLE_SIZE))));
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = f_build_tab();

    typedef enum logic [3:0] {
        S_IDLE, S_R2, S_RD, S_SQ, S_SIL, S_IDX, S_IDXW, S_ACC,
        S_DEN, S_DIV, S_DIVW, S_OUT
    } t_state;

    t_state r_state;

    // Configuration
    logic [CFG_W-1:0] r_kind;
    logic [CFG_W-1:0] r_dims;

    // Loader
    logic [CW-1:0] r_cnt;
    logic          r_ovf;

    // Sequencer datapath
    logic [DIST_W-1:0]    r_rad;
    logic [31:0]          r_r2;
    logic [31:0]          r_d2;
    logic [63:0]          r_term;
    logic [EXP_W-1:0]     r_tab;
    logic [NUMW-1:0]      r_num;
    logic [CW-1:0]        r_n;
    logic [CW-1:0]        r_i;
    logic [31:0]          r_den [DEN_LIMBS];
    logic [1:0]           r_limb;
    logic [31:0]          r_carry;
    logic [2:0]           r_pow;
    logic                 r_gpend;

    // Pending result and output register
    logic [EST_W-1:0]    r_res_est;
    logic [COUNT_W-1:0]  r_res_cnt;
    logic [STATUS_W-1:0] r_res_st;
    logic                r_out_valid;
    logic [EST_W-1:0]    r_est;
    logic [COUNT_W-1:0]  r_count;
    logic [STATUS_W-1:0] r_status;

    logic              w_acc;
    logic              w_store_now;
    logic              w_ovf_now;
    logic [CW-1:0]     w_n_now;
    logic [DIST_W-1:0] w_q;
    logic [31:0]       w_ma;
    logic [31:0]       w_mb;
    logic [31:0]       w_mc;
    logic [63:0]       w_mp;
    logic [63:0]       w_term;
    logic              w_lt;
    logic              w_div_start;
    logic [DIV_W-1:0]  w_div_num;
    logic [DIV_W-1:0]  w_div_dsh;
    logic [STEP_W-1:0] w_div_steps;
    logic              w_div_done;
    logic [QUO_W-1:0]  w_quo;
    logic [EW-1:0]     w_idx_num;
    logic [DIV_W-1:0]  w_num_sh;
    logic [DIV_W-1:0]  w_den_flat;
    logic [2:0]        w_powr;
    logic [EXP_W-1:0]  w_gterm;

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_estimate = r_est;
    assign o_count    = r_count;
    assign o_status   = r_status;

    assign w_acc       = i_valid && !o_stall;
    assign w_store_now = w_acc && (r_cnt < CW'(MAX_NEIGHBORS));
    assign w_ovf_now   = r_ovf || (r_cnt >= CW'(MAX_NEIGHBORS));
    assign w_n_now     = r_cnt + CW'(1);

    kkde_store #(.DEPTH(MAX_NEIGHBORS), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_store_now),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_distance),
        .i_re    (r_state == S_RD),
        .i_raddr (r_i[AW-1:0]),
        .o_q     (w_q)
    );

    // Multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        w_mc = '0;
        unique case (r_state)
            S_R2: begin
                w_ma = 32'(r_rad);
                w_mb = 32'(r_rad);
            end
            S_SQ: begin
                w_ma = 32'(w_q);
                w_mb = 32'(w_q);
            end
            S_SIL: begin
                w_ma = r_r2 - r_d2;
                w_mb = r_r2 - r_d2;
            end
            S_DEN: begin
                w_ma = r_den[r_limb];
                w_mb = (r_pow != 3'd0) ? 32'(r_rad) : G_SCALE;
                w_mc = r_carry;
            end
            default: begin
                w_ma = '0;
            end
        endcase
    end

    kkde_mul u_mul (
        .i_a (w_ma),
        .i_b (w_mb),
        .i_c (w_mc),
        .o_p (w_mp)
    );

    // Per-distance kernel term
    assign w_lt    = (w_q < r_rad);
    assign w_gterm = (r_tab > E_BETA) ? r_tab - E_BETA : '0;
    always_comb begin
        unique case (r_kind)
            KIND_EPAN:  w_term = w_lt ? 64'(r_r2 - r_d2) : 64'd0;
            KIND_CONE:  w_term = w_lt ? 64'(r_rad - w_q) : 64'd0;
            KIND_GAUSS: w_term = w_lt ? 64'(w_gterm)
                               : (w_q == r_rad) ? 64'(E_ONE - E_BETA) : 64'd0;
            default:    w_term = w_lt ? r_term : 64'd0;
        endcase
    end

    // Denominator power of R per kernel
    always_comb begin
        unique case (r_kind)
            KIND_EPAN:  w_powr = {1'b0, r_dims} + 3'd2;
            KIND_CONE:  w_powr = {1'b0, r_dims} + 3'd1;
            KIND_GAUSS: w_powr = {1'b0, r_dims};
            default:    w_powr = {1'b0, r_dims} + 3'd4;
        endcase
    end

    // Numerator scaled by 2^(16*dims+24)
    always_comb begin
        unique case (r_dims)
            2'd0:    w_num_sh = DIV_W'(r_num) << 24;
            2'd1:    w_num_sh = DIV_W'(r_num) << 40;
            2'd2:    w_num_sh = DIV_W'(r_num) << 56;
            default: w_num_sh = DIV_W'(r_num) << 72;
        endcase
    end

    assign w_den_flat = DIV_W'({r_den[3], r_den[2], r_den[1], r_den[0]});
    assign w_idx_num  = EW'(r_d2) * EW'(EXP_TABLE_SIZE);

    // Divider request: table index or final quotient
    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = w_num_sh;
        w_div_dsh   = w_den_flat << 64;
        w_div_steps = STEP_W'(QUO_W);
        if (r_state == S_IDX) begin
            w_div_start = 1'b1;
            w_div_num   = DIV_W'(w_idx_num);
            w_div_dsh   = DIV_W'(r_r2) << (QB - 1);
            w_div_steps = STEP_W'(QB);
        end else if (r_state == S_DIV) begin
            w_div_start = 1'b1;
        end
    end

    kkde_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_dsh   (w_div_dsh),
        .i_steps (w_div_steps),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_EPAN;
            r_dims <= 2'd2;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                REG_KIND: r_kind <= i_wr_data;
                REG_DIMS: r_dims <= i_wr_data;
            endcase
        end
    end

    // Sequencer, loader and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && r_state != S_OUT) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (i_last) begin
                            r_cnt     <= '0;
                            r_ovf     <= 1'b0;
                            r_n       <= w_n_now;
                            r_rad     <= i_distance;
                            r_num     <= '0;
                            r_i       <= '0;
                            r_res_est <= '0;
                            r_res_cnt <= w_ovf_now ? '0
                                       : (w_n_now > CW'(127)) ? COUNT_W'(127)
                                       : COUNT_W'(w_n_now);
                            if (w_ovf_now) begin
                                r_res_st  <= ST_OVERFLOW;
                                r_state   <= S_OUT;
                            end else if (i_distance == '0) begin
                                r_res_st  <= ST_ZERO_RAD;
                                r_state   <= S_OUT;
                            end else begin
                                r_state   <= S_R2;
                            end
                        end else if (w_store_now) begin
                            r_cnt <= w_n_now;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                S_R2: begin
                    r_r2    <= w_mp[31:0];
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_d2 <= w_mp[31:0];
                    unique case (r_kind)
                        KIND_SILV:  r_state <= S_SIL;
                        KIND_GAUSS: r_state <= w_lt ? S_IDX : S_ACC;
                        default:    r_state <= S_ACC;
                    endcase
                end
                S_SIL: begin
                    r_term  <= w_mp;
                    r_state <= S_ACC;
                end
                S_IDX: begin
                    r_state <= S_IDXW;
                end
                S_IDXW: begin
                    if (w_div_done) begin
                        r_tab   <= EXP_TAB[w_quo[QB-1:0]];
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_num <= r_num + NUMW'(w_term);
                    r_i   <= r_i + CW'(1);
                    if (r_i + CW'(1) == r_n) begin
                        r_den[0] <= 32'd1;
                        for (int j = 1; j < DEN_LIMBS; j++) r_den[j] <= '0;
                        r_limb   <= '0;
                        r_carry  <= '0;
                        r_pow    <= w_powr;
                        r_gpend  <= (r_kind == KIND_GAUSS);
                        r_state  <= S_DEN;
                    end else begin
                        r_state  <= S_RD;
                    end
                end
                S_DEN: begin
                    if (r_pow == 3'd0 && !r_gpend) begin
                        r_state <= S_DIV;
                    end else begin
                        // One limb of den * m per cycle
                        r_den[r_limb] <= w_mp[31:0];
                        r_carry       <= (r_limb == 2'(DEN_LIMBS - 1)) ? '0 : w_mp[63:32];
                        r_limb        <= r_limb + 2'd1;
                        if (r_limb == 2'(DEN_LIMBS - 1)) begin
                            if (r_pow != 3'd0) r_pow   <= r_pow - 3'd1;
                            else               r_gpend <= 1'b0;
                        end
                    end
                end
                S_DIV: begin
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (w_div_done) begin
                        if (w_quo[QUO_W-1]) begin
                            r_res_est <= '1;
                            r_res_st  <= ST_SAT;
                        end else begin
                            r_res_est <= w_quo[EST_W-1:0];
                            r_res_st  <= ST_OK;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_est       <= r_res_est;
                        r_count     <= r_res_cnt;
                        r_status    <= r_res_st;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
